>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	localparam int unsigned ByteW      = 8;
	localparam int unsigned OpcodeW    = 4;
	localparam int unsigned LengthW    = 64;
	localparam int unsigned CountW     = 4;
	localparam int unsigned QueueDepth = 2;

	localparam logic [6:0]        LenCode16   = 7'd126;
	localparam logic [6:0]        LenCode64   = 7'd127;
	localparam logic [CountW-1:0] ExtBytes16  = 4'd2;
	localparam logic [CountW-1:0] ExtBytes64  = 4'd8;
	localparam logic [CountW-1:0] MaskKeyLen  = 4'd4;

	typedef enum logic [4:0] {
		PH_BYTE0   = 5'b00001,
		PH_BYTE1   = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASKKEY = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	typedef struct packed {
		logic               is_header;
		logic [OpcodeW-1:0] frame_opcode;
		logic               was_masked;
		logic [LengthW-1:0] frame_length;
		logic [ByteW-1:0]   payload_byte;
		logic               last_in_frame;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_byte_if / wsd_result_if
// valid/ready channels for received bytes and deframed results
// ----------------------------------------------------------------------------
`default_nettype none

interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_result_if;
	logic        valid;
	logic        ready;
	logic        is_header;
	logic [3:0]  frame_opcode;
	logic        was_masked;
	logic [63:0] frame_length;
	logic [7:0]  payload_byte;
	logic        last_in_frame;

	modport source (
		output valid, output is_header, output frame_opcode, output was_masked,
		output frame_length, output payload_byte, output last_in_frame, input ready
	);
	modport sink (
		input valid, input is_header, input frame_opcode, input was_masked,
		input frame_length, input payload_byte, input last_in_frame, output ready
	);
endinterface

`default_nettype wire

>>> rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// frame header state machine and payload counter, one byte per transaction
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_take,
	input  wire logic [7:0]           byte_in,
	output      logic                 res_valid,
	output      wsd_pkg::result_t     res
);
	import wsd_pkg::*;

	phase_t               phase_q, phase_d;
	logic [CountW-1:0]    togo_q, togo_d, togo_dec;
	logic [LengthW-1:0]   len_q, len_d;
	logic [LengthW-1:0]   rem_q, rem_d;
	logic [OpcodeW-1:0]   op_q, op_d;
	logic                 mask_q, mask_d;
	logic [6:0]           code;
	logic                 finish;
	logic                 pay_last;

	assign code     = byte_in[6:0];
	assign togo_dec = togo_q - CountW'(togo_q != '0);
	assign pay_last = (rem_q <= LengthW'(1));

	always_comb begin
		phase_d   = phase_q;
		togo_d    = togo_q;
		len_d     = len_q;
		rem_d     = rem_q;
		op_d      = op_q;
		mask_d    = mask_q;
		finish    = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_BYTE1: begin
				mask_d = byte_in[7];
				if (code == LenCode16) begin
					len_d   = '0;
					togo_d  = ExtBytes16;
					phase_d = PH_EXTLEN;
				end else if (code == LenCode64) begin
					len_d   = '0;
					togo_d  = ExtBytes64;
					phase_d = PH_EXTLEN;
				end else begin
					len_d = LengthW'(code);
					if (byte_in[7]) begin
						phase_d = PH_MASKKEY;
						togo_d  = MaskKeyLen;
					end else begin
						finish = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				len_d  = {len_q[LengthW-ByteW-1:0], byte_in};
				togo_d = togo_dec;
				if (togo_dec == '0) begin
					if (mask_q) begin
						phase_d = PH_MASKKEY;
						togo_d  = MaskKeyLen;
					end else begin
						finish = 1'b1;
					end
				end
			end
			PH_MASKKEY: begin
				togo_d = togo_dec;
				if (togo_dec == '0) begin
					finish = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				rem_d     = rem_q - LengthW'(rem_q != '0);
				if (pay_last) begin
					phase_d = PH_BYTE0;
				end
				res_valid = 1'b1;
				res.is_header     = 1'b0;
				res.frame_opcode  = op_q;
				res.was_masked    = mask_q;
				res.frame_length  = len_q;
				res.payload_byte  = byte_in;
				res.last_in_frame = pay_last;
			end
			default: begin
				op_d    = byte_in[OpcodeW-1:0];
				mask_d  = 1'b0;
				len_d   = '0;
				rem_d   = '0;
				togo_d  = '0;
				phase_d = PH_BYTE1;
			end
		endcase
		if (finish) begin
			rem_d     = len_d;
			phase_d   = (len_d == '0) ? PH_BYTE0 : PH_PAYLOAD;
			res_valid = 1'b1;
			res.is_header     = 1'b1;
			res.frame_opcode  = op_d;
			res.was_masked    = mask_d;
			res.frame_length  = len_d;
			res.payload_byte  = '0;
			res.last_in_frame = (len_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BYTE0;
			togo_q  <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			op_q    <= '0;
			mask_q  <= 1'b0;
		end else if (byte_take) begin
			phase_q <= phase_d;
			togo_q  <= togo_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/wsd_out_queue.sv
// ----------------------------------------------------------------------------
// wsd_out_queue
// two-entry result register that decouples the parser from a stalled receiver
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_out_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire wsd_pkg::result_t push_data,
	output      logic             has_room,
	wsd_result_if.source          out
);
	import wsd_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);

	result_t             mem_q [QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]       count_q;
	logic                pop;
	result_t             head;

	assign has_room = (count_q != (PtrW+1)'(QueueDepth));
	assign pop      = out.valid && out.ready;
	assign head     = mem_q[rd_ptr_q];

	assign out.valid         = (count_q != '0);
	assign out.is_header     = head.is_header;
	assign out.frame_opcode  = head.frame_opcode;
	assign out.was_masked    = head.was_masked;
	assign out.frame_length  = head.frame_length;
	assign out.payload_byte  = head.payload_byte;
	assign out.last_in_frame = head.last_in_frame;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

>>> rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// splits a received byte stream into websocket frame headers and payload bytes
// ----------------------------------------------------------------------------
// channels: rx takes one stream byte per transaction; frame gives one result
// per transaction, either a header (opcode, mask flag, decoded length) or a
// payload byte with its last flag. header bytes other than the one that
// completes the header give no result; the mask key is skipped, not applied.
// throughput: one byte per cycle while rx is ready, set by the header/payload
// state update in the parser. a result is written into the result register
// when the byte that causes it is taken, and is offered on frame from there.
// a two-entry result register sits between parser and frame, so rx stays
// ready while one result waits; rx drops ready only when both entries are
// held by a stalled receiver, and no result is ever lost.
// reset: arst_n clears the parser to await the first header byte of a frame
// and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	wsd_byte_if.sink    rx,
	wsd_result_if.source frame
);
	import wsd_pkg::*;

	logic    byte_take;
	logic    has_room;
	logic    res_valid;
	result_t res;

	assign rx.ready  = has_room;
	assign byte_take = rx.valid && rx.ready;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_take (byte_take),
		.byte_in   (rx.rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (byte_take && res_valid),
		.push_data (res),
		.has_room  (has_room),
		.out       (frame)
	);

endmodule

`default_nettype wire
